// File: rtl/core/mlpx_pkg.sv
// ----------------------------------------------------------------------------
// mlpx_pkg
// shared constants, types and arithmetic helpers of the lidar point converter
// ----------------------------------------------------------------------------
`default_nettype none
package mlpx_pkg;

  // coefficient format
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int COEF_REG_W = 54;
  localparam int INST_REG_W = 36;
  localparam int KW = COEF_W + 2;
  localparam int NW = COEF_W + 3;
  localparam int RW = COEF_W + 6;

  // register widths padded so every field slice exists, missing bits are zero
  localparam int COEF_EXT_W = (3 * COEF_W > COEF_REG_W) ? 3 * COEF_W : COEF_REG_W;
  localparam int INST_EXT_W = (2 * COEF_W > INST_REG_W) ? 2 * COEF_W : INST_REG_W;

  // reset values: direction (0, -1, 0), install angle of -20 degrees
  localparam int COEF_ONE = 1 << COEF_FRAC_BITS;
  localparam int INST_COS = int'(0.9396926207859084 * real'(COEF_ONE));
  localparam int INST_SIN = int'(-0.3420201433256687 * real'(COEF_ONE));
  localparam logic [COEF_REG_W-1:0] COEF_RESET =
    COEF_REG_W'({COEF_W'(0), COEF_W'(-COEF_ONE), COEF_W'(0)});
  localparam logic [INST_REG_W-1:0] INST_RESET =
    INST_REG_W'({COEF_W'(INST_SIN), COEF_W'(INST_COS)});

  // range gate and output clamp
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] MIN_RANGE_MM = 24'd500;
  localparam int OUT_W = 25;
  localparam logic signed [63:0] SAT_HI = 64'sd16777215;
  localparam logic signed [63:0] SAT_LO = -64'sd16777216;

  // code to radians: m = mag*ANG_Q + round((mag*ANG_RM) / 368640)
  localparam logic [63:0] ANG_Q = 64'd9150;
  localparam logic [63:0] ANG_RM = 64'd203426;
  localparam logic [63:0] ANG_HALF = 64'd184320;
  localparam int ANG_SHIFT = 13;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  // reciprocals for exact small-constant division
  localparam int DIV3_S = 30;
  localparam logic [63:0] DIV3_R = ((64'd1 << DIV3_S) + 64'd2) / 64'd3;
  localparam int DIV15_S = 24;
  localparam logic [63:0] DIV15_R = ((64'd1 << DIV15_S) + 64'd14) / 64'd15;
  localparam int DIV45_S = 28;
  localparam logic [63:0] DIV45_R = ((64'd1 << DIV45_S) + 64'd44) / 64'd45;

  typedef enum logic [1:0] {
    CFG_COEF0   = 2'd0,
    CFG_COEF1   = 2'd1,
    CFG_COEF2   = 2'd2,
    CFG_INSTALL = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic adv;
  } pipe_ctl_t;

  typedef logic signed [30:0] sin_t;
  typedef logic signed [31:0] cos_t;

  function automatic logic [23:0] div3(logic [23:0] u);
    logic [63:0] p;
    p = 64'(u) * DIV3_R;
    return 24'(p >> DIV3_S);
  endfunction

  function automatic logic [17:0] div15(logic [17:0] u);
    logic [63:0] p;
    p = 64'(u) * DIV15_R;
    return 18'(p >> DIV15_S);
  endfunction

  function automatic logic [20:0] div45(logic [20:0] u);
    logic [63:0] p;
    p = 64'(u) * DIV45_R;
    return 21'(p >> DIV45_S);
  endfunction

  // unsigned q30 product rounding
  function automatic logic [63:0] rsu(logic [63:0] v);
    return (v + HALF_Q30) >> 30;
  endfunction

  // shift right rounding half away from zero
  function automatic logic signed [63:0] rs(logic signed [63:0] v, int unsigned s);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (s - 1);
    mag = 64'(-v);
    if (!v[63]) begin
      return signed'((64'(v) + half) >> s);
    end
    return -signed'((mag + half) >> s);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat25(logic signed [63:0] v);
    if (v > SAT_HI) begin
      return OUT_W'(SAT_HI);
    end
    if (v < SAT_LO) begin
      return OUT_W'(SAT_LO);
    end
    return OUT_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mirror_lidar_point_to_xyz.sv
// ----------------------------------------------------------------------------
// mirror_lidar_point_to_xyz
// raw mirror lidar return to saturated cartesian point in millimetres
// ----------------------------------------------------------------------------
// One return is taken per clock unless a held result stalls the pipeline.
// The datapath is a fixed twelve-stage pipeline: an input register, six
// stages of sine/cosine polynomial per mirror angle, four stages of
// reflection and install rotation, and one stage of range scaling and clamp.
// All stages move together; a stall on the result side holds the whole
// pipeline and in_ready drops in the same cycle. Returns shorter than 500 mm
// are dropped and leave a bubble. Configuration writes take effect for items
// that enter stage 8 after them and are meant to be issued while the
// pipeline is empty; cfg_ready is always high.
`default_nettype none
module mirror_lidar_point_to_xyz
  import mlpx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input return channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [15:0]           in_raw_horizon,
  input  wire logic [15:0]           in_raw_vertical,
  input  wire logic [15:0]           in_raw_distance,
  input  wire logic [7:0]            in_distance_unit,
  input  wire logic [7:0]            in_reflectivity,
  input  wire logic [1:0]            in_channel,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OUT_W-1:0]    out_x_mm,
  output logic signed [OUT_W-1:0]    out_y_mm,
  output logic signed [OUT_W-1:0]    out_z_mm,
  output logic [7:0]                 out_intensity,
  output logic [1:0]                 out_ring,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COEF_REG_W-1:0] cfg_data
);

  localparam int LAST = 11;

  pipe_ctl_t ctl;

  // configuration registers
  logic [COEF_REG_W-1:0] coef0_r, coef1_r, coef2_r;
  logic [INST_REG_W-1:0] inst_r;

  // sideband travelling with the item, index is the stage number
  logic              v_r    [1:LAST];
  logic [DIST_W-1:0] d_r    [1:LAST];
  logic [7:0]        refl_r [1:LAST];
  logic [1:0]        ch_r   [1:LAST];

  logic [15:0] mag_h_r, mag_v_r;
  logic        neg_h_r, neg_v_r;

  logic [DIST_W-1:0] d_in;
  logic [15:0]       mag_h_in, mag_v_in;

  sin_t sin_h, sin_v;
  cos_t cos_h, cos_v;
  logic [COEF_REG_W-1:0] coef_sel;
  logic signed [NW-1:0] nx;
  logic signed [RW-1:0] ry, rz;

  logic signed [63:0] d64;

  // output register
  logic                    out_v_r;
  logic signed [OUT_W-1:0] x_r, y_r, z_r;
  logic [7:0]              inten_r;
  logic [1:0]              ring_r;

  // whole pipeline advances unless a finished point is held
  assign ctl.adv   = !out_v_r || out_ready;
  assign in_ready  = ctl.adv;
  assign cfg_ready = 1'b1;

  // mirror code to angle magnitude, sign kept apart
  always_comb begin
    d_in     = DIST_W'(in_raw_distance) * DIST_W'(in_distance_unit);
    mag_h_in = in_raw_horizon[15] ? {1'b0, in_raw_horizon[14:0]}
                                  : 16'(17'h08000 - 17'(in_raw_horizon));
    mag_v_in = in_raw_vertical[15] ? {1'b0, in_raw_vertical[14:0]}
                                   : 16'(17'h08000 - 17'(in_raw_vertical));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef0_r <= COEF_RESET;
      coef1_r <= COEF_RESET;
      coef2_r <= COEF_RESET;
      inst_r  <= INST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF0:   coef0_r <= cfg_data;
        CFG_COEF1:   coef1_r <= cfg_data;
        CFG_COEF2:   coef2_r <= cfg_data;
        CFG_INSTALL: inst_r  <= cfg_data[INST_REG_W-1:0];
        default:     ;
      endcase
    end
  end

  // valid chain, short returns never enter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAST; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (ctl.adv) begin
      v_r[1] <= in_valid && (d_in >= MIN_RANGE_MM);
      for (int i = 2; i <= LAST; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // payload of stage 1 and sideband shift line
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mag_h_r   <= mag_h_in;
      neg_h_r   <= !in_raw_horizon[15];
      mag_v_r   <= mag_v_in;
      neg_v_r   <= !in_raw_vertical[15];
      d_r[1]    <= d_in;
      refl_r[1] <= in_reflectivity;
      ch_r[1]   <= in_channel;
      for (int i = 2; i <= LAST; i++) begin
        d_r[i]    <= d_r[i-1];
        refl_r[i] <= refl_r[i-1];
        ch_r[i]   <= ch_r[i-1];
      end
    end
  end

  // stages 2 to 7: trig of both mirror angles
  mlpx_sincos u_sc_h (
    .clk   (clk),
    .ctl   (ctl),
    .mag   (mag_h_r),
    .neg   (neg_h_r),
    .sin_o (sin_h),
    .cos_o (cos_h)
  );

  mlpx_sincos u_sc_v (
    .clk   (clk),
    .ctl   (ctl),
    .mag   (mag_v_r),
    .neg   (neg_v_r),
    .sin_o (sin_v),
    .cos_o (cos_v)
  );

  // channel three picks an all-zero direction
  always_comb begin
    case (ch_r[7])
      2'd0:    coef_sel = coef0_r;
      2'd1:    coef_sel = coef1_r;
      2'd2:    coef_sel = coef2_r;
      default: coef_sel = '0;
    endcase
  end

  // stages 8 to 11: reflection and install rotation
  mlpx_reflect u_refl (
    .clk       (clk),
    .ctl       (ctl),
    .sin_h     (sin_h),
    .cos_h     (cos_h),
    .sin_v     (sin_v),
    .cos_v     (cos_v),
    .coef_word (coef_sel),
    .inst_word (inst_r),
    .nx_o      (nx),
    .ry_o      (ry),
    .rz_o      (rz)
  );

  // stage 12: scale by range, round, clamp
  assign d64 = signed'(64'(d_r[LAST]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ctl.adv) begin
      out_v_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      x_r     <= sat25(rs(d64 * 64'(nx), COEF_FRAC_BITS));
      y_r     <= sat25(rs(d64 * 64'(ry), COEF_FRAC_BITS));
      z_r     <= sat25(rs(d64 * 64'(rz), COEF_FRAC_BITS));
      inten_r <= refl_r[LAST];
      ring_r  <= ch_r[LAST];
    end
  end

  assign out_valid     = out_v_r;
  assign out_x_mm      = x_r;
  assign out_y_mm      = y_r;
  assign out_z_mm      = z_r;
  assign out_intensity = inten_r;
  assign out_ring      = ring_r;

endmodule
`default_nettype wire

// File: rtl/core/mlpx_sincos.sv
// ----------------------------------------------------------------------------
// mlpx_sincos
// six-stage pipeline: mirror code magnitude to q30 sine and cosine
// ----------------------------------------------------------------------------
`default_nettype none
module mlpx_sincos
  import mlpx_pkg::*;
(
  input  wire logic      clk,
  input  wire pipe_ctl_t ctl,
  input  wire logic [15:0] mag,
  input  wire logic      neg,
  output sin_t           sin_o,
  output cos_t           cos_o
);

  logic [20:0] u_r;
  logic [29:0] mq_r;
  logic        neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  logic [29:0] m3_r, m4_r, m5_r, m6_r;
  logic [27:0] m2_4_r, m2_5_r;
  logic [25:0] p3_r;
  logic [23:0] p4_r;
  logic [27:0] q2_r;
  logic [23:0] q3_r, q4_r;
  logic [21:0] p5_r;
  logic [19:0] p6_r;
  sin_t        sin_r;
  cos_t        cos_r;

  logic [63:0] t_s2, m_s3, m2_s4, m3_s5, m4_s5, m5_s6, m6_s6;
  logic [17:0] q5_s7;
  logic [20:0] q6_s7;
  logic [29:0] sv_s7;
  logic [30:0] cv_s7;

  always_comb begin
    t_s2  = 64'(mag) * ANG_RM + ANG_HALF;
    m_s3  = 64'(mq_r) + 64'(div45(u_r));
    m2_s4 = rsu(64'(m3_r) * 64'(m3_r));
    m3_s5 = rsu(64'(m2_4_r) * 64'(m4_r));
    m4_s5 = rsu(64'(m2_4_r) * 64'(m2_4_r));
    m5_s6 = rsu(64'(p4_r) * 64'(m5_r));
    m6_s6 = rsu(64'(p4_r) * 64'(m2_5_r));
    q5_s7 = div15(18'((22'(p5_r) + 22'd60) >> 3));
    q6_s7 = div45(21'((20'(p6_r) + 20'd360) >> 4));
    sv_s7 = 30'(m6_r - 30'(q3_r) + 30'(q5_s7));
    cv_s7 = 31'(ONE_Q30 - 64'(q2_r) + 64'(q4_r) - 64'(q6_s7));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      // stage 2: split the radian scale into quotient and remainder parts
      u_r    <= 21'(t_s2 >> ANG_SHIFT);
      mq_r   <= 30'(64'(mag) * ANG_Q);
      neg2_r <= neg;
      // stage 3
      m3_r   <= 30'(m_s3);
      neg3_r <= neg2_r;
      // stage 4
      m4_r   <= m3_r;
      m2_4_r <= 28'(m2_s4);
      neg4_r <= neg3_r;
      // stage 5
      m5_r   <= m4_r;
      m2_5_r <= m2_4_r;
      p3_r   <= 26'(m3_s5);
      p4_r   <= 24'(m4_s5);
      neg5_r <= neg4_r;
      // stage 6
      m6_r   <= m5_r;
      q2_r   <= 28'((29'(m2_5_r) + 29'd1) >> 1);
      q3_r   <= div3(24'((27'(p3_r) + 27'd3) >> 1));
      q4_r   <= div3(24'((25'(p4_r) + 25'd12) >> 3));
      p5_r   <= 22'(m5_s6);
      p6_r   <= 20'(m6_s6);
      neg6_r <= neg5_r;
      // stage 7
      sin_r  <= neg6_r ? -sin_t'({1'b0, sv_s7}) : sin_t'({1'b0, sv_s7});
      cos_r  <= cos_t'({1'b0, cv_s7});
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// File: rtl/core/mlpx_reflect.sv
// ----------------------------------------------------------------------------
// mlpx_reflect
// four-stage pipeline: mirror reflection of the channel direction and
// install rotation
// ----------------------------------------------------------------------------
`default_nettype none
module mlpx_reflect
  import mlpx_pkg::*;
(
  input  wire logic                  clk,
  input  wire pipe_ctl_t             ctl,
  input  wire sin_t                  sin_h,
  input  wire cos_t                  cos_h,
  input  wire sin_t                  sin_v,
  input  wire cos_t                  cos_v,
  input  wire logic [COEF_REG_W-1:0] coef_word,
  input  wire logic [INST_REG_W-1:0] inst_word,
  output logic signed [NW-1:0]       nx_o,
  output logic signed [RW-1:0]       ry_o,
  output logic signed [RW-1:0]       rz_o
);

  logic [COEF_EXT_W-1:0] coef_ext;
  logic [INST_EXT_W-1:0] inst_ext;

  logic signed [31:0]       cvsh8_r, cvch8_r, sv8_r, cvsh9_r, cvch9_r, sv9_r;
  logic signed [COEF_W-1:0] cx8_r, cy8_r, cz8_r, ci8_r, si8_r;
  logic signed [COEF_W-1:0] cx9_r, cy9_r, cz9_r, ci9_r, si9_r, ci10_r, si10_r;
  logic signed [KW-1:0]     k9_r;
  logic signed [NW-1:0]     nx10_r, ny10_r, nz10_r, nx11_r;
  logic signed [RW-1:0]     ry11_r, rz11_r;

  logic signed [63:0] cvsh_s8, cvch_s8, k_s9, nx_s10, ny_s10, nz_s10, ry_s11, rz_s11;

  always_comb begin
    coef_ext = COEF_EXT_W'(coef_word);
    inst_ext = INST_EXT_W'(inst_word);
    cvsh_s8 = rs(64'(cos_v) * 64'(sin_h), 30);
    cvch_s8 = rs(64'(cos_v) * 64'(cos_h), 30);
    k_s9 = rs(-(64'(cvsh8_r) * 64'(cx8_r)) + 64'(cvch8_r) * 64'(cy8_r)
              + 64'(sv8_r) * 64'(cz8_r), 30);
    nx_s10 = 64'(cx9_r) + rs(64'sd2 * 64'(cvsh9_r) * 64'(k9_r), 30);
    ny_s10 = 64'(cy9_r) - rs(64'sd2 * 64'(cvch9_r) * 64'(k9_r), 30);
    nz_s10 = 64'(cz9_r) - rs(64'sd2 * 64'(sv9_r) * 64'(k9_r), 30);
    ry_s11 = rs(64'(ny10_r) * 64'(ci10_r) - 64'(nz10_r) * 64'(si10_r), COEF_FRAC_BITS);
    rz_s11 = rs(64'(ny10_r) * 64'(si10_r) + 64'(nz10_r) * 64'(ci10_r), COEF_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      // stage 8: mirror normal terms, field unpack
      cvsh8_r <= 32'(cvsh_s8);
      cvch8_r <= 32'(cvch_s8);
      sv8_r   <= 32'(sin_v);
      cx8_r   <= coef_ext[0 +: COEF_W];
      cy8_r   <= coef_ext[COEF_W +: COEF_W];
      cz8_r   <= coef_ext[2*COEF_W +: COEF_W];
      ci8_r   <= inst_ext[0 +: COEF_W];
      si8_r   <= inst_ext[COEF_W +: COEF_W];
      // stage 9: projection on the normal
      k9_r    <= KW'(k_s9);
      cvsh9_r <= cvsh8_r;
      cvch9_r <= cvch8_r;
      sv9_r   <= sv8_r;
      cx9_r   <= cx8_r;
      cy9_r   <= cy8_r;
      cz9_r   <= cz8_r;
      ci9_r   <= ci8_r;
      si9_r   <= si8_r;
      // stage 10: reflected direction
      nx10_r  <= NW'(nx_s10);
      ny10_r  <= NW'(ny_s10);
      nz10_r  <= NW'(nz_s10);
      ci10_r  <= ci9_r;
      si10_r  <= si9_r;
      // stage 11: install rotation about x
      nx11_r  <= nx10_r;
      ry11_r  <= RW'(ry_s11);
      rz11_r  <= RW'(rz_s11);
    end
  end

  assign nx_o = nx11_r;
  assign ry_o = ry11_r;
  assign rz_o = rz11_r;

endmodule
`default_nettype wire

// File: rtl/core/mlpx_checker.sv
// ----------------------------------------------------------------------------
// mlpx_checker
// port-level checks of the lidar point converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module mlpx_checker
  import mlpx_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic signed [OUT_W-1:0] out_x_mm,
  input wire logic signed [OUT_W-1:0] out_y_mm,
  input wire logic signed [OUT_W-1:0] out_z_mm,
  input wire logic [7:0]            out_intensity,
  input wire logic [1:0]            out_ring
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_mm) && $stable(out_y_mm)
      && $stable(out_z_mm) && $stable(out_intensity) && $stable(out_ring))
    else $error("result changed while stalled");

  // pipeline only stops when a result is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // unused channel gives the origin
  a_ring3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ring == 2'd3 |-> out_x_mm == '0 && out_y_mm == '0 && out_z_mm == '0)
    else $error("channel three point not at origin");

endmodule

bind mirror_lidar_point_to_xyz mlpx_checker u_mlpx_checker (.*);
`default_nettype wire
